FILE: hw/rtl/assert_macros.svh
// assertion macros for the vertex depth visibility test block
// expects clk and arst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define VDVT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vdvt assertion failed");

// next-cycle implication, off during reset
`define VDVT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vdvt assertion failed");

`endif

FILE: hw/rtl/vdvt_pkg.sv
// shared constants and types of the vertex depth visibility test block
// no dependencies; used by the interfaces, the divider and the top level
package vdvt_pkg;

	localparam int MAX_PIXELS = 1048576;
	localparam int MAX_SIDE   = 2048;
	localparam int PIX_AW     = $clog2(MAX_PIXELS);
	localparam int SIDE_W     = $clog2(MAX_SIDE) + 1;
	localparam int COORD_W    = $clog2(MAX_SIDE);

	localparam int MAG_W      = 64;
	localparam int REM_W      = 32;
	localparam int DIV_BITS   = 49;

	localparam logic [7:0] MASK_OFF = 8'd255;

	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_TOL    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X      = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y      = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 4'd7;

	localparam logic [1:0] FN_POSE  = 2'd0;
	localparam logic [1:0] FN_DEPTH = 2'd1;
	localparam logic [1:0] FN_MASK  = 2'd2;
	localparam logic [1:0] FN_TEST  = 2'd3;

	localparam logic [2:0] RS_VISIBLE  = 3'd0;
	localparam logic [2:0] RS_BEHIND   = 3'd1;
	localparam logic [2:0] RS_OUTSIDE  = 3'd2;
	localparam logic [2:0] RS_TOO_FAR  = 3'd3;
	localparam logic [2:0] RS_MASKED   = 3'd4;
	localparam logic [2:0] RS_MISMATCH = 3'd5;

	// item data that rides alongside the divider
	typedef struct packed {
		logic [1:0]        func;
		logic [PIX_AW-1:0] pix;
		logic [31:0]       data;
		logic signed [31:0] z;
		logic              neg_x;
		logic              neg_y;
		logic [2:0]        reason;
	} side_t;

	typedef struct packed {
		logic              visible;
		logic [2:0]        reason;
		logic signed [15:0] col;
		logic signed [15:0] row;
		logic signed [31:0] depth;
	} result_t;

endpackage

FILE: hw/rtl/vdvt_if.sv
// channel interfaces of the vertex depth visibility test block
// depends on vdvt_pkg for the pixel address and register index widths
interface vdvt_item_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  func;
	logic [3:0]                  entry_index;
	logic [vdvt_pkg::PIX_AW-1:0] pixel_index;
	logic signed [31:0]          data_value;
	logic signed [31:0]          point_x;
	logic signed [31:0]          point_y;
	logic signed [31:0]          point_z;
	modport source(output valid, func, entry_index, pixel_index, data_value,
		point_x, point_y, point_z, input ready);
	modport sink(input valid, func, entry_index, pixel_index, data_value,
		point_x, point_y, point_z, output ready);
endinterface

interface vdvt_result_if;
	logic               valid;
	logic               ready;
	logic               visible;
	logic [2:0]         reason;
	logic signed [15:0] pixel_col;
	logic signed [15:0] pixel_row;
	logic signed [31:0] point_depth;
	modport source(output valid, visible, reason, pixel_col, pixel_row, point_depth,
		input ready);
	modport sink(input valid, visible, reason, pixel_col, pixel_row, point_depth,
		output ready);
endinterface

interface vdvt_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [vdvt_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                    data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: hw/rtl/vdvt_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on vdvt_pkg; flags quotients of 2^DIV_BITS and above as overflow
module vdvt_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [vdvt_pkg::MAG_W-1:0]   mag,
	input  logic [vdvt_pkg::REM_W-1:0]   den,
	output logic [vdvt_pkg::DIV_BITS-1:0] quo,
	output logic                         ovf
);
	localparam int NB = vdvt_pkg::DIV_BITS;
	localparam int MW = vdvt_pkg::MAG_W;
	localparam int RW = vdvt_pkg::REM_W;

	logic [RW-1:0] rem_s [NB];
	logic [NB-1:0] q_s   [NB];
	logic [MW-1:0] mag_s [NB];
	logic [RW-1:0] den_s [NB];
	logic          ovf_s [NB];

	genvar k;
	generate
		for (k = 0; k < NB; k++) begin : g_stage
			logic [RW-1:0] prev_rem;
			logic [NB-1:0] prev_q;
			logic [MW-1:0] prev_mag;
			logic [RW-1:0] prev_den;
			logic          prev_ovf;
			logic [RW:0]   trial;
			logic          ge;

			if (k == 0) begin : g_first
				// high part of the dividend already at or above the divisor: overflow
				assign prev_rem = {{(RW-(MW-NB)){1'b0}}, mag[MW-1:NB]};
				assign prev_q   = '0;
				assign prev_mag = mag;
				assign prev_den = den;
				assign prev_ovf = prev_rem >= den;
			end else begin : g_next
				assign prev_rem = rem_s[k-1];
				assign prev_q   = q_s[k-1];
				assign prev_mag = mag_s[k-1];
				assign prev_den = den_s[k-1];
				assign prev_ovf = ovf_s[k-1];
			end

			assign trial = {prev_rem, prev_mag[NB-1-k]};
			assign ge    = trial >= {1'b0, prev_den};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? RW'(trial - {1'b0, prev_den}) : RW'(trial);
					q_s[k]   <= prev_q | (NB'(ge) << (NB-1-k));
					mag_s[k] <= prev_mag;
					den_s[k] <= prev_den;
					ovf_s[k] <= prev_ovf;
				end
			end
		end
	endgenerate

	assign quo = q_s[NB-1];
	assign ovf = ovf_s[NB-1];

endmodule

FILE: hw/rtl/vertex_depth_visibility_test.sv
// vertex depth visibility test: pinhole projection of a world point and depth check
// depends on vdvt_pkg, the channel interfaces in vdvt_if.sv and vdvt_div
//
// item channel: load words (pose entry, depth pixel, mask pixel) and test words.
// load words write the pose registers or the depth and mask images and give no
// result; a test word gives one result word on the result channel.
// cfg channel: register writes, always ready; the user must make them only while the
// block is idle, and the block itself does not enforce this. a test word passes
// through 3 stages of transform and products, the 49 stages of the two quotient
// dividers, 4 stages of rounding, bounds and image read, and the output register.
// throughput: one word per cycle while not stalled, in any mix of loads and tests.
// a depth or mask load takes effect at the image read stage, so words keep order.
// reset clears the pose to zero, loads the default registers and empties the
// pipeline; the images are not cleared and hold nothing until loaded.
// when the receiver stalls, a two-word output buffer catches the word in flight
// and the whole pipeline then holds, with item ready low, until space frees up.
module vertex_depth_visibility_test (
	input  logic                  clk,
	input  logic                  arst_n,
	vdvt_item_if.sink             item,
	vdvt_result_if.source         result,
	vdvt_cfg_if.sink              cfg
);
	`include "assert_macros.svh"

	localparam int NB  = vdvt_pkg::DIV_BITS;
	localparam int AW  = vdvt_pkg::PIX_AW;
	localparam int SW  = vdvt_pkg::SIDE_W;
	localparam int CW  = vdvt_pkg::COORD_W;
	localparam logic [NB-1:0] Q_LIMIT = NB'(1) << (NB-1);
	localparam logic [SW-1:0] SIDE_LIMIT = SW'(vdvt_pkg::MAX_SIDE);

	// configuration
	logic [11:0] width_q, height_q;
	logic [31:0] max_depth_q, tol_q, fx_q, fy_q, cx_q, cy_q;
	logic signed [31:0] pose_q [12];

	// pipeline control
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_dly [NB];

	// stage payloads
	logic signed [63:0] prod_s1 [3][3];
	logic signed [31:0] trans_s1 [3];
	logic [1:0]         func_s1, func_s2;
	logic [AW-1:0]      pix_s1, pix_s2;
	logic [31:0]        data_s1, data_s2;
	logic signed [31:0] cam_s2 [3];
	logic signed [49:0] acc [3];

	logic [63:0]        mag_x_s3, mag_y_s3;
	vdvt_pkg::side_t    side_s3, side_s4, side_s5, side_s6, side_s7;
	vdvt_pkg::side_t    side_dly [NB];
	logic [31:0]        abs_x, abs_y;

	logic [NB-1:0]      quo_x, quo_y;
	logic               ovf_x, ovf_y;
	logic [NB-1:0]      qc_x, qc_y;
	logic signed [50:0] sum_x_s4, sum_y_s4;

	logic signed [15:0] col_s5, row_s5, col_s6, row_s6, col_s7, row_s7;
	logic [SW-1:0]      w_lim, h_lim;
	logic               outside;
	logic [2*SW-1:0]    lin;
	logic [AW-1:0]      addr_s6;

	logic [31:0]        depth_mem [vdvt_pkg::MAX_PIXELS];
	logic [7:0]         mask_mem [vdvt_pkg::MAX_PIXELS];
	logic [31:0]        sens_s7;
	logic [7:0]         maskv_s7;

	logic signed [32:0] diff;
	logic [32:0]        adiff;
	logic [2:0]         final_reason;
	vdvt_pkg::result_t  res_new, out_q, skid_q;
	logic               out_v_q, skid_v_q, push, pop;

	function automatic logic signed [15:0] round_sat(input logic signed [50:0] s);
		logic [50:0] m;
		logic [50:0] r;
		begin
			m = s[50] ? 51'(-s) : 51'(s);
			r = (m + 51'd32768) >> 16;
			if (!s[50]) begin
				round_sat = (r > 51'd32767) ? 16'sd32767 : 16'(r);
			end else begin
				round_sat = (r > 51'd32768) ? -16'sd32768 : 16'(51'd0 - r);
			end
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [49:0] a);
		begin
			if (a > 50'sd2147483647) sat32 = 32'sh7fffffff;
			else if (a < -50'sd2147483648) sat32 = 32'sh80000000;
			else sat32 = a[31:0];
		end
	endfunction

	assign en         = !skid_v_q;
	assign item.ready = en;
	assign cfg.ready  = 1'b1;

	// configuration registers and pose
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 12'd640;
			height_q    <= 12'd480;
			max_depth_q <= 32'd196608;
			tol_q       <= 32'd1966;
			fx_q        <= 32'd34406400;
			fy_q        <= 32'd34406400;
			cx_q        <= 32'd20938752;
			cy_q        <= 32'd15695872;
			for (int i = 0; i < 12; i++) pose_q[i] <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					vdvt_pkg::CFG_IMAGE_WIDTH:  width_q     <= cfg.data[11:0];
					vdvt_pkg::CFG_IMAGE_HEIGHT: height_q    <= cfg.data[11:0];
					vdvt_pkg::CFG_MAX_DEPTH:    max_depth_q <= cfg.data;
					vdvt_pkg::CFG_DEPTH_TOL:    tol_q       <= cfg.data;
					vdvt_pkg::CFG_FOCAL_X:      fx_q        <= cfg.data;
					vdvt_pkg::CFG_FOCAL_Y:      fy_q        <= cfg.data;
					vdvt_pkg::CFG_CENTER_X:     cx_q        <= cfg.data;
					vdvt_pkg::CFG_CENTER_Y:     cy_q        <= cfg.data;
					default: ;
				endcase
			end
			if (en && item.valid && item.func == vdvt_pkg::FN_POSE
					&& item.entry_index < 4'd12) begin
				pose_q[item.entry_index] <= item.data_value;
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int i = 0; i < NB; i++) v_dly[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid && item.func != vdvt_pkg::FN_POSE;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_dly[0] <= v_s3;
			for (int i = 1; i < NB; i++) v_dly[i] <= v_dly[i-1];
			v_s4 <= v_dly[NB-1];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// s1: pose products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][0] <= 64'(pose_q[r*4]) * 64'(item.point_x);
				prod_s1[r][1] <= 64'(pose_q[r*4+1]) * 64'(item.point_y);
				prod_s1[r][2] <= 64'(pose_q[r*4+2]) * 64'(item.point_z);
				trans_s1[r]   <= pose_q[r*4+3];
			end
			func_s1 <= item.func;
			pix_s1  <= item.pixel_index;
			data_s1 <= item.data_value;
		end
	end

	// s2: floor of each product, sum and saturate
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = 50'(trans_s1[r]) + 50'(prod_s1[r][0] >>> 16)
				+ 50'(prod_s1[r][1] >>> 16) + 50'(prod_s1[r][2] >>> 16);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) cam_s2[r] <= sat32(acc[r]);
			func_s2 <= func_s1;
			pix_s2  <= pix_s1;
			data_s2 <= data_s1;
		end
	end

	// s3: depth class and numerators
	assign abs_x = cam_s2[0][31] ? 32'(-cam_s2[0]) : 32'(cam_s2[0]);
	assign abs_y = cam_s2[1][31] ? 32'(-cam_s2[1]) : 32'(cam_s2[1]);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_x_s3       <= 64'(abs_x) * 64'(fx_q);
			mag_y_s3       <= 64'(abs_y) * 64'(fy_q);
			side_s3.func   <= func_s2;
			side_s3.pix    <= pix_s2;
			side_s3.data   <= data_s2;
			side_s3.z      <= cam_s2[2];
			side_s3.neg_x  <= cam_s2[0][31];
			side_s3.neg_y  <= cam_s2[1][31];
			if (cam_s2[2] < 0) side_s3.reason <= vdvt_pkg::RS_BEHIND;
			else if (cam_s2[2] == 0) side_s3.reason <= vdvt_pkg::RS_OUTSIDE;
			else side_s3.reason <= vdvt_pkg::RS_VISIBLE;
		end
	end

	vdvt_div u_div_x (
		.clk (clk),
		.en  (en),
		.mag (mag_x_s3),
		.den (side_s3.z),
		.quo (quo_x),
		.ovf (ovf_x)
	);

	vdvt_div u_div_y (
		.clk (clk),
		.en  (en),
		.mag (mag_y_s3),
		.den (side_s3.z),
		.quo (quo_y),
		.ovf (ovf_y)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_dly[0] <= side_s3;
			for (int i = 1; i < NB; i++) side_dly[i] <= side_dly[i-1];
		end
	end

	// s4: clamp quotient, apply sign, add principal point
	assign qc_x = (ovf_x || quo_x > Q_LIMIT) ? Q_LIMIT : quo_x;
	assign qc_y = (ovf_y || quo_y > Q_LIMIT) ? Q_LIMIT : quo_y;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_x_s4 <= (side_dly[NB-1].neg_x ? -$signed({2'b0, qc_x}) : $signed({2'b0, qc_x}))
				+ $signed({19'b0, cx_q});
			sum_y_s4 <= (side_dly[NB-1].neg_y ? -$signed({2'b0, qc_y}) : $signed({2'b0, qc_y}))
				+ $signed({19'b0, cy_q});
			side_s4  <= side_dly[NB-1];
		end
	end

	// s5: round half away from zero and saturate; zero when the item is not visible
	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s4.reason == vdvt_pkg::RS_VISIBLE) begin
				col_s5 <= round_sat(sum_x_s4);
				row_s5 <= round_sat(sum_y_s4);
			end else begin
				col_s5 <= '0;
				row_s5 <= '0;
			end
			side_s5 <= side_s4;
		end
	end

	// s6: bounds test and pixel address
	assign w_lim = (width_q > SIDE_LIMIT) ? SIDE_LIMIT : width_q;
	assign h_lim = (height_q > SIDE_LIMIT) ? SIDE_LIMIT : height_q;
	assign outside = col_s5[15] || row_s5[15] || (16'(col_s5) >= 16'(w_lim))
		|| (16'(row_s5) >= 16'(h_lim));
	assign lin = (2*SW)'(row_s5[CW-1:0]) * (2*SW)'(w_lim) + (2*SW)'(col_s5[CW-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			col_s6  <= col_s5;
			row_s6  <= row_s5;
			side_s6 <= side_s5;
			if (side_s5.reason == vdvt_pkg::RS_VISIBLE && outside) begin
				side_s6.reason <= vdvt_pkg::RS_OUTSIDE;
			end
			addr_s6 <= (side_s5.func == vdvt_pkg::FN_TEST) ? lin[AW-1:0] : side_s5.pix;
		end
	end

	// s7: image stores, loads write and tests read at the same stage
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s6 && side_s6.func == vdvt_pkg::FN_DEPTH) depth_mem[addr_s6] <= side_s6.data;
			sens_s7 <= depth_mem[addr_s6];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s6 && side_s6.func == vdvt_pkg::FN_MASK) mask_mem[addr_s6] <= side_s6.data[7:0];
			maskv_s7 <= mask_mem[addr_s6];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s7  <= col_s6;
			row_s7  <= row_s6;
			side_s7 <= side_s6;
		end
	end

	// final depth tests
	assign diff  = 33'(side_s7.z) - 33'($signed(sens_s7));
	assign adiff = diff[32] ? 33'(-diff) : 33'(diff);

	always_comb begin
		final_reason = side_s7.reason;
		if (side_s7.reason == vdvt_pkg::RS_VISIBLE) begin
			if ($signed(33'($signed(sens_s7))) > $signed({1'b0, max_depth_q})) begin
				final_reason = vdvt_pkg::RS_TOO_FAR;
			end else if (maskv_s7 == vdvt_pkg::MASK_OFF) begin
				final_reason = vdvt_pkg::RS_MASKED;
			end else if (adiff >= {1'b0, tol_q}) begin
				final_reason = vdvt_pkg::RS_MISMATCH;
			end
		end
	end

	assign res_new.visible = final_reason == vdvt_pkg::RS_VISIBLE;
	assign res_new.reason  = final_reason;
	assign res_new.col     = col_s7;
	assign res_new.row     = row_s7;
	assign res_new.depth   = side_s7.z;

	// output register with skid word
	assign push = en && v_s7 && side_s7.func == vdvt_pkg::FN_TEST;
	assign pop  = out_v_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (pop) begin
					out_q    <= skid_q;
					skid_v_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_v_q || pop) begin
					out_q   <= res_new;
					out_v_q <= 1'b1;
				end else begin
					skid_q   <= res_new;
					skid_v_q <= 1'b1;
				end
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign result.valid       = out_v_q;
	assign result.visible     = out_q.visible;
	assign result.reason      = out_q.reason;
	assign result.pixel_col   = out_q.col;
	assign result.pixel_row   = out_q.row;
	assign result.point_depth = out_q.depth;

	`VDVT_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q)
	`VDVT_ASSERT_IMP(a_visible_reason, result.valid,
		result.visible == (result.reason == vdvt_pkg::RS_VISIBLE))
	`VDVT_ASSERT_IMP(a_behind_no_pixel, result.valid && result.reason == vdvt_pkg::RS_BEHIND,
		result.pixel_col == 16'sd0 && result.pixel_row == 16'sd0)

endmodule

FILE: verif/tb_top.sv
// testbench for the vertex depth visibility test block: loads pose and images,
// tests points, checks all results against typed rows or local projection model
// depends on vdvt_pkg, the channel interfaces in vdvt_if.sv and the block's rtl
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TIMEOUT_CYCLES = 20000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RAND_ITEMS = 500;

	typedef struct packed {
		logic [1:0]         func;
		logic [3:0]         entry_index;
		logic [19:0]        pixel_index;
		logic signed [31:0] data_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} item_t;

	typedef struct packed {
		logic               visible;
		logic [2:0]         reason;
		logic signed [15:0] col;
		logic signed [15:0] row;
		logic signed [31:0] depth;
	} verdict_t;

	// directed row: item, whether a typed-in result is given, and that result
	typedef struct {
		item_t    it;
		bit       fixed;
		verdict_t res;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;

	vdvt_item_if   item();
	vdvt_result_if result();
	vdvt_cfg_if    cfg();

	vertex_depth_visibility_test dut (.clk(clk), .arst_n(arst_n), .item(item.sink),
		.result(result.source), .cfg(cfg.sink));

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// model state
	longint pose [12];
	logic [31:0] depth_img [int];
	logic [7:0] mask_img [int];
	longint img_w, img_h, max_depth, depth_tol, fx, fy, cx, cy;

	verdict_t verdict_q[$];
	int mismatches = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	bit timed_out = 0;
	int counts [6];
	bit long_stall = 0;

	function automatic longint floor_q16(longint p);
		if (p >= 0) return p >>> 16;
		return -((-p + 65535) >>> 16);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint round_px(longint a, longint f, longint c, longint z);
		logic [63:0] mag, q;
		longint s, u;
		mag = (a < 0 ? -a : a) * f;
		q = mag / z;
		if (q > 64'd1 << 48) q = 64'd1 << 48;
		s = a < 0 ? -longint'(q) : longint'(q);
		u = s + c;
		u = u >= 0 ? ((u + 32768) >>> 16) : -((-u + 32768) >>> 16);
		return clamp(u, -32768, 32767);
	endfunction

	function automatic verdict_t project_point(item_t it);
		verdict_t v;
		longint pt [3], cam [3], acc, col, row, w, h, sensor, diff;
		int adr;
		logic [2:0] rs;
		pt[0] = it.point_x; pt[1] = it.point_y; pt[2] = it.point_z;
		for (int r = 0; r < 3; r++) begin
			acc = pose[r*4+3];
			for (int c = 0; c < 3; c++) acc += floor_q16(pose[r*4+c] * pt[c]);
			cam[r] = clamp(acc, -64'sd2147483648, 64'sd2147483647);
		end
		w = img_w > vdvt_pkg::MAX_SIDE ? vdvt_pkg::MAX_SIDE : img_w;
		h = img_h > vdvt_pkg::MAX_SIDE ? vdvt_pkg::MAX_SIDE : img_h;
		col = 0; row = 0;
		if (cam[2] < 0) rs = vdvt_pkg::RS_BEHIND;
		else if (cam[2] == 0) rs = vdvt_pkg::RS_OUTSIDE;
		else begin
			col = round_px(cam[0], fx, cx, cam[2]);
			row = round_px(cam[1], fy, cy, cam[2]);
			if (col < 0 || row < 0 || col >= w || row >= h) rs = vdvt_pkg::RS_OUTSIDE;
			else begin
				adr = int'((row * w + col) % vdvt_pkg::MAX_PIXELS);
				sensor = depth_img.exists(adr) ? longint'($signed(depth_img[adr])) : 0;
				diff = cam[2] - sensor;
				if (diff < 0) diff = -diff;
				if (sensor > max_depth) rs = vdvt_pkg::RS_TOO_FAR;
				else if (mask_img.exists(adr) && mask_img[adr] == vdvt_pkg::MASK_OFF)
					rs = vdvt_pkg::RS_MASKED;
				else if (diff < depth_tol) rs = vdvt_pkg::RS_VISIBLE;
				else rs = vdvt_pkg::RS_MISMATCH;
			end
		end
		v.visible = rs == vdvt_pkg::RS_VISIBLE;
		v.reason = rs;
		v.col = col[15:0];
		v.row = row[15:0];
		v.depth = cam[2][31:0];
		return v;
	endfunction

	// updates the model on acceptance; tests also queue their expected verdict
	function automatic void absorb_item(item_t it, bit fixed, verdict_t res);
		verdict_t v;
		case (it.func)
			vdvt_pkg::FN_POSE: if (it.entry_index < 4'd12) pose[it.entry_index] = it.data_value;
			vdvt_pkg::FN_DEPTH: depth_img[int'(it.pixel_index)] = it.data_value;
			vdvt_pkg::FN_MASK: mask_img[int'(it.pixel_index)] = it.data_value[7:0];
			default: begin
				v = project_point(it);
				if (fixed && v != res)
					$display("note: model disagrees with typed row %h vs %h", v, res);
				verdict_q.insert(verdict_q.size(), fixed ? res : v);
			end
		endcase
	endfunction

	function automatic void set_reg(logic [vdvt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
		case (idx)
			vdvt_pkg::CFG_IMAGE_WIDTH:  img_w = d[11:0];
			vdvt_pkg::CFG_IMAGE_HEIGHT: img_h = d[11:0];
			vdvt_pkg::CFG_MAX_DEPTH:    max_depth = d;
			vdvt_pkg::CFG_DEPTH_TOL:    depth_tol = d;
			vdvt_pkg::CFG_FOCAL_X:      fx = d;
			vdvt_pkg::CFG_FOCAL_Y:      fy = d;
			vdvt_pkg::CFG_CENTER_X:     cx = d;
			vdvt_pkg::CFG_CENTER_Y:     cy = d;
			default: ;
		endcase
	endfunction

	task automatic write_reg(logic [vdvt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		set_reg(idx, d);
		@(negedge clk);
		cfg.valid <= 0;
		@(negedge clk);
	endtask

	int burst_left = 0;

	// offers one word, with bursty gaps, returns after acceptance
	task automatic send_word(item_t it, bit fixed, verdict_t res);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				item.valid <= 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		item.valid <= 1;
		{item.func, item.entry_index, item.pixel_index, item.data_value,
			item.point_x, item.point_y, item.point_z} <= it;
		do @(posedge clk); while (!item.ready);
		absorb_item(it, fixed, res);
		@(negedge clk);
	endtask

	task automatic drain();
		item.valid <= 0;
		while (verdict_q.size() != 0 && !timed_out) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// receiver stall pattern, with one long hold-off on request
	bit hold_req = 0;
	always @(negedge clk) begin
		if (hold_req && !long_stall) begin
			long_stall = 1;
			result.ready <= 0;
			repeat (200) @(negedge clk);
			result.ready <= 1;
		end else begin
			result.ready <= ($urandom_range(0, 15) < 3) ? 0 : 1;
		end
	end

	// checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item.valid && item.ready) || (result.valid && result.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > TIMEOUT_CYCLES && !timed_out) begin
				timed_out = 1;
				$display("timeout, %0d verdicts pending", verdict_q.size());
				$display("TEST FAILED");
				$finish;
			end
			if (result.valid && result.ready) begin
				verdict_t exp_v, got;
				got = {result.visible, result.reason, result.pixel_col, result.pixel_row,
					result.point_depth};
				results_seen++;
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result word %h", got);
				end else begin
					exp_v = verdict_q.pop_front();
					counts[got.reason < 6 ? got.reason : 0]++;
					if (got !== exp_v) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: vis %b/%b reason %0d/%0d col %0d/%0d row %0d/%0d depth %0d/%0d",
								exp_v.visible, got.visible, exp_v.reason, got.reason,
								exp_v.col, got.col, exp_v.row, got.row,
								exp_v.depth, got.depth);
					end
				end
			end
		end
	end

	function automatic item_t mk(logic [1:0] f, logic [3:0] e, logic [19:0] p,
			logic [31:0] d, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		item_t it;
		it.func = f; it.entry_index = e; it.pixel_index = p; it.data_value = d;
		it.point_x = x; it.point_y = y; it.point_z = z;
		return it;
	endfunction

	function automatic verdict_t vd(logic [2:0] rs, logic [31:0] dep);
		verdict_t v;
		v.visible = rs == vdvt_pkg::RS_VISIBLE; v.reason = rs; v.col = '0; v.row = '0;
		v.depth = dep;
		return v;
	endfunction

	function automatic logic [31:0] rnd32();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	row_t rows[$];
	item_t it;
	int sent;

	function automatic void add_row(item_t ri, bit fixed, verdict_t res);
		row_t r;
		r.it = ri; r.fixed = fixed; r.res = res;
		rows.insert(rows.size(), r);
	endfunction

	task automatic load_pose(longint t0, longint t1, longint t2);
		// identity rotation with a translation
		for (int k = 0; k < 12; k++) begin
			logic [31:0] d;
			d = (k == 0 || k == 5 || k == 10) ? 32'h0001_0000 : 32'd0;
			if (k == 3) d = 32'(t0);
			if (k == 7) d = 32'(t1);
			if (k == 11) d = 32'(t2);
			send_word(mk(vdvt_pkg::FN_POSE, 4'(k), '0, d, '0, '0, '0), 0, '0);
		end
	endtask

	// fills the small image with depths near z and a few masked pixels
	task automatic load_image(int w, int h, logic [31:0] z);
		for (int p = 0; p < w * h; p++) begin
			send_word(mk(vdvt_pkg::FN_DEPTH, '0, 20'(p), z + $urandom_range(0, 3000) - 1500,
				'0, '0, '0), 0, '0);
			send_word(mk(vdvt_pkg::FN_MASK, '0, 20'(p), ($urandom_range(0, 5) == 0) ? 32'hff :
				$urandom, '0, '0, '0), 0, '0);
		end
	endtask

	// well-formed test aimed at the image, sometimes off-target or noisy
	// tame keeps every test on the aimed points
	task automatic random_test(int w, int h, logic [31:0] z, bit tame);
		item_t ti;
		int k;
		k = $urandom_range(0, 9);
		ti = mk(vdvt_pkg::FN_TEST, 4'($urandom), 20'($urandom), $urandom, '0, '0, '0);
		if (k < 7 || tame) begin
			ti.point_x = $urandom_range(0, 65535 * 4) - 131072;
			ti.point_y = $urandom_range(0, 65535 * 4) - 131072;
			ti.point_z = z + $urandom_range(0, 4000) - 2000 - 32'h0002_0000;
		end else begin
			ti.point_x = rnd32(); ti.point_y = rnd32(); ti.point_z = rnd32();
		end
		send_word(ti, 0, '0);
	endtask

	initial begin
		item.valid = 0; item.func = 0; item.entry_index = 0; item.pixel_index = 0;
		item.data_value = 0; item.point_x = 0; item.point_y = 0; item.point_z = 0;
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
		foreach (pose[k]) pose[k] = 0;
		img_w = 640; img_h = 480; max_depth = 196608; depth_tol = 1966;
		fx = 34406400; fy = 34406400; cx = 20938752; cy = 15695872;
		repeat (3) @(negedge clk);
		arst_n = 1;

		// directed: zero pose gives zero depth, then behind, bad index, extremes
		add_row(mk(vdvt_pkg::FN_TEST, '0, '0, '0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff),
			1, vd(vdvt_pkg::RS_OUTSIDE, 32'd0));
		add_row(mk(vdvt_pkg::FN_POSE, 4'd11, '0, 32'hffff_0000, '0, '0, '0), 0, '0);
		add_row(mk(vdvt_pkg::FN_TEST, '0, '0, '0, '0, '0, '0), 1,
			vd(vdvt_pkg::RS_BEHIND, 32'hffff_0000));
		add_row(mk(vdvt_pkg::FN_POSE, 4'd15, '0, 32'h0005_0000, '0, '0, '0), 0, '0);
		add_row(mk(vdvt_pkg::FN_TEST, '0, '0, '0, 32'd1, 32'd2, 32'd3), 1,
			vd(vdvt_pkg::RS_BEHIND, 32'hffff_0000));
		// center pixel (320,240), row*640+col = 153920
		add_row(mk(vdvt_pkg::FN_DEPTH, '0, 20'd153920, 32'h0001_0000, '0, '0, '0), 0, '0);
		add_row(mk(vdvt_pkg::FN_MASK, '0, 20'd153920, 32'h0, '0, '0, '0), 0, '0);
		add_row(mk(vdvt_pkg::FN_POSE, 4'd10, '0, 32'h7fff_ffff, '0, '0, '0), 0, '0);
		add_row(mk(vdvt_pkg::FN_TEST, '0, '0, '0, '0, '0, 32'h7fff_ffff), 0, '0);
		add_row(mk(vdvt_pkg::FN_TEST, '0, '0, '0, '0, '0, 32'h8000_0000), 0, '0);
		add_row(mk(vdvt_pkg::FN_POSE, 4'd10, '0, 32'h0001_0000, '0, '0, '0), 0, '0);
		add_row(mk(vdvt_pkg::FN_POSE, 4'd11, '0, '0, '0, '0, '0), 0, '0);
		add_row(mk(vdvt_pkg::FN_POSE, 4'd0, '0, 32'h0001_0000, '0, '0, '0), 0, '0);
		add_row(mk(vdvt_pkg::FN_POSE, 4'd5, '0, 32'h0001_0000, '0, '0, '0), 0, '0);
		add_row(mk(vdvt_pkg::FN_TEST, '0, '0, '0, '0, '0, 32'h0001_0000), 0, '0);
		add_row(mk(vdvt_pkg::FN_TEST, '0, '0, '0, '0, '0, 32'h0002_0000), 0, '0);
		add_row(mk(vdvt_pkg::FN_MASK, '0, 20'd153920, 32'hffff_ffff, '0, '0, '0), 0, '0);
		add_row(mk(vdvt_pkg::FN_TEST, '0, '0, '0, '0, '0, 32'h0001_0000), 0, '0);
		add_row(mk(vdvt_pkg::FN_DEPTH, '0, 20'd153920, 32'h7fff_ffff, '0, '0, '0), 0, '0);
		add_row(mk(vdvt_pkg::FN_TEST, '0, '0, '0, '0, '0, 32'h0001_0000), 0, '0);
		add_row(mk(vdvt_pkg::FN_TEST, '0, '0, '0, 32'h7fff_ffff, 32'h8000_0000, 32'd1), 0, '0);
		add_row(mk(vdvt_pkg::FN_TEST, '0, '0, '0, 32'h8000_0000, 32'h7fff_ffff, 32'd1), 0, '0);
		add_row(mk(vdvt_pkg::FN_DEPTH, '0, 20'hfffff, 32'h8000_0000, '0, '0, '0), 0, '0);
		add_row(mk(vdvt_pkg::FN_MASK, '0, 20'hfffff, 32'h0, '0, '0, '0), 0, '0);
		foreach (rows[i]) send_word(rows[i].it, rows[i].fixed, rows[i].res);
		drain();

		// random phases over several settings; small images keep loads cheap
		sent = 0;
		for (int ph = 0; ph < 5 && !timed_out; ph++) begin
			int w, h;
			logic [31:0] z;
			w = (ph == 4) ? 4095 : $urandom_range(1, 6);
			h = (ph == 4) ? 1 : $urandom_range(1, 6);
			if (ph == 3) begin w = 1; h = 1; end
			z = $urandom_range(2, 8) << 16;
			write_reg(vdvt_pkg::CFG_IMAGE_WIDTH, w);
			write_reg(vdvt_pkg::CFG_IMAGE_HEIGHT, h);
			write_reg(vdvt_pkg::CFG_MAX_DEPTH, ph == 0 ? 32'hffff_ffff :
				(ph == 1 ? 32'd0 : z + 1000));
			write_reg(vdvt_pkg::CFG_DEPTH_TOL, ph == 2 ? 32'hffff_ffff :
				(ph == 1 ? 32'd0 : 32'd1200));
			write_reg(vdvt_pkg::CFG_FOCAL_X, ph == 3 ? 32'd0 : (ph == 4 ? 32'hffff_ffff :
				$urandom_range(1, 4) << 16));
			write_reg(vdvt_pkg::CFG_FOCAL_Y, ph == 3 ? 32'hffff_ffff :
				($urandom_range(1, 4) << 16));
			write_reg(vdvt_pkg::CFG_CENTER_X, ph == 4 ? 32'hffff_ffff : (w << 15));
			write_reg(vdvt_pkg::CFG_CENTER_Y, ph == 3 ? 32'd0 : (h << 15));
			if (ph == 4) begin w = 6; h = 1; end
			load_pose($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
				z + 32'h0002_0000);
			load_image(w, h, z);
			for (int n = 0; n < RAND_ITEMS / 5; n++) begin
				if (ph == 1 && n == 20) hold_req = 1;
				if ($urandom_range(0, 15) == 0)
					send_word(mk(2'($urandom_range(0, 2)), 4'($urandom_range(12, 15)), '0,
						rnd32(), '0, '0, '0), 0, '0);
				else
					// the wide image has only a short loaded row, keep tests off the rest
					random_test(w, h, z, ph == 4);
				sent++;
				if (n == 60) drain();
			end
			drain();
		end

		$display("covered %0d random words over 5 settings, %0d results checked", sent,
			results_seen);
		$display("reasons seen: vis %0d behind %0d outside %0d far %0d masked %0d mis %0d",
			counts[0], counts[1], counts[2], counts[3], counts[4], counts[5]);
		if (mismatches == 0 && verdict_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d pending", mismatches, verdict_q.size());
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
